FILE: sv/tpm_pkg.sv
`timescale 1ns / 1ps
package tpm_pkg;
  localparam int unsigned PAIR_COUNT = 6;
  localparam int unsigned PULSE_FRAC_BITS = 8;
  localparam logic [19:0] CARRY_MAX = 20'hFFFFF;

  typedef enum logic [1:0] {
    CFG_INV_ARM = 2'd0,
    CFG_GAIN    = 2'd1,
    CFG_MAX     = 2'd2,
    CFG_MIN     = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAIR,
    ST_DIV,
    ST_THR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [47:0] dividend;
    logic [47:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [47:0] quotient;
  } div_rsp_t;
endpackage

FILE: sv/tpm_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module tpm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tpm_pkg::div_req_t req,
  output tpm_pkg::div_rsp_t rsp
);
  import tpm_pkg::*;

  logic [47:0] quo_r, quo_nxt;
  logic [47:0] rem_r, rem_nxt;
  logic [47:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [48:0] trial;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r, quo_r[47]} - {1'b0, den_r};
    if (req.start) begin
      quo_nxt = req.dividend;
      rem_nxt = '0;
      den_nxt = req.divisor;
      cnt_nxt = 6'd47;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[48]) begin
        rem_nxt = trial[47:0];
        quo_nxt = {quo_r[46:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[46:0], quo_r[47]};
        quo_nxt = {quo_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quotient = quo_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> $past(busy_r))
    else $error("divider done without busy");
  a_no_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> !busy_r)
    else $error("divider busy and done together");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r)
    else $error("divider did not start");
endmodule

FILE: sv/thruster_pulse_mixer.sv
`timescale 1ns / 1ps
// Thruster pulse mixer. One force/torque beat yields twelve result beats, thrusters 0..11
// in order, the last flagged by out_last_thruster. The block takes one command at a time.
// The six pair demands are computed in turn on one shared datapath (torque scale and sum,
// then gain); each thruster then goes through demand select and carry update, then one output beat.
// When the largest demand exceeds the maximum pulse, each nonzero thruster demand is
// scaled by its own pass through a 48-bit restoring divider, at most six passes per
// command. Receiver stalls on an output beat hold the sequencer and so delay the next
// accept. Configuration is written through cfg_valid/cfg_ready while idle; carries
// reset to zero.
module thruster_pulse_mixer #(
  parameter int unsigned THRUSTER_COUNT = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_force_x,
  input  logic signed [15:0] in_force_y,
  input  logic signed [15:0] in_force_z,
  input  logic signed [15:0] in_torque_x,
  input  logic signed [15:0] in_torque_y,
  input  logic signed [15:0] in_torque_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_thruster_index,
  output logic [9:0]         out_on_time,
  output logic [9:0]         out_close_time,
  output logic               out_last_thruster,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import tpm_pkg::*;

  localparam int unsigned PSH = 29 - PULSE_FRAC_BITS;

  // configuration
  logic [15:0] inv_arm_r, gain_r;
  logic [9:0]  max_ms_r, min_ms_r;

  // captured command
  logic signed [15:0] frc_r [3];
  logic signed [15:0] trq_r [3];

  state_t state_r, state_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [31:0] dem_r [PAIR_COUNT];      // demand per pair
  logic [PAIR_COUNT-1:0] neg_r;         // pair picked its second thruster
  logic [31:0] large_r;
  logic [31:0] scl_r;                    // scaled demand of current thruster
  logic [33:0] mag_r;                    // magnitude of current pair demand
  logic        phase_r;
  logic [19:0] carry_r [THRUSTER_COUNT];
  logic [9:0]  on_r, off_r;
  logic        scale_r;

  div_req_t dreq;
  div_rsp_t drsp;

  tpm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [31:0] max_fix, min_fix;
  assign max_fix = 32'(max_ms_r) << PULSE_FRAC_BITS;
  assign min_fix = 32'(min_ms_r) << PULSE_FRAC_BITS;

  // pair demand: torque scale and sum first, registered, then gain
  logic [1:0]  axis;
  logic signed [33:0] tq, fq, dd;
  logic [33:0] mag;
  logic [49:0] prod;
  logic [31:0] pdem;
  always_comb begin
    axis = 2'(idx_r >> 1);
    unique case (axis)
      2'd0: tq = 34'(trq_r[1]) * $signed({1'b0, inv_arm_r});
      2'd1: tq = 34'(trq_r[2]) * $signed({1'b0, inv_arm_r});
      default: tq = 34'(trq_r[0]) * $signed({1'b0, inv_arm_r});
    endcase
    unique case (axis)
      2'd0: fq = 34'(frc_r[0]) <<< 8;
      2'd1: fq = 34'(frc_r[1]) <<< 8;
      default: fq = 34'(frc_r[2]) <<< 8;
    endcase
    dd = idx_r[0] ? fq - tq : fq + tq;
    mag = dd[33] ? 34'(-dd) : dd;
    prod = 50'(gain_r) * 50'(mag_r);
    pdem = 32'(prod >> PSH);
  end

  // thruster step
  logic [2:0]  pair;
  logic        mine;
  logic [31:0] rawd;
  logic [20:0] csum;
  logic [19:0] csat, cnew;
  logic [19:0] pint;
  logic [9:0]  pulse, on_c;
  always_comb begin
    pair = (idx_r >= 4'(PAIR_COUNT)) ? 3'(idx_r - 4'(PAIR_COUNT)) : idx_r[2:0];
    mine = (idx_r >= 4'(PAIR_COUNT)) == neg_r[pair];
    rawd = mine ? dem_r[pair] : 32'd0;
    csum = 21'(carry_r[idx_r]) + 21'(scl_r);
    csat = csum[20] ? CARRY_MAX : csum[19:0];
    pint = csat >> PULSE_FRAC_BITS;
    pulse = '0;
    cnew = csat;
    if (32'(csat) >= min_fix) begin
      pulse = (pint > 20'(max_ms_r)) ? max_ms_r : pint[9:0];
      cnew = csat - (20'(pulse) << PULSE_FRAC_BITS);
    end
    on_c = (max_ms_r - pulse) >> 1;
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) begin
        state_nxt = ST_PAIR;
        idx_nxt = '0;
      end
      ST_PAIR: if (phase_r) begin
        idx_nxt = idx_r + 4'd1;
        if (idx_r == 4'(PAIR_COUNT - 1)) begin
          idx_nxt = '0;
          state_nxt = ST_THR;
        end
      end
      ST_THR: begin
        if (phase_r) state_nxt = ST_OUT;
        else if (scale_r && rawd != 32'd0) state_nxt = ST_DIV;
      end
      ST_DIV: if (drsp.done) state_nxt = ST_THR;
      ST_OUT: if (!out_stall) begin
        idx_nxt = idx_r + 4'd1;
        state_nxt = ST_THR;
        if (idx_r == 4'(THRUSTER_COUNT - 1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    cfg_ready = (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT);
    // scaled demand = demand * max_fix / largest, one division per nonzero thruster when scaling
    dreq.start = (state_r == ST_THR) && !phase_r && scale_r && (rawd != 32'd0);
    dreq.dividend = ({16'd0, rawd} * {38'd0, max_ms_r}) << PULSE_FRAC_BITS;
    dreq.divisor = 48'(large_r);
  end

  assign out_thruster_index = idx_r;
  assign out_on_time = on_r;
  assign out_close_time = off_r;
  assign out_last_thruster = (idx_r == 4'(THRUSTER_COUNT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r <= '0;
      phase_r <= 1'b0;
      inv_arm_r <= 16'd2560;
      gain_r <= 16'd25600;
      max_ms_r <= 10'd200;
      min_ms_r <= 10'd10;
      for (int i = 0; i < THRUSTER_COUNT; i++) carry_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_INV_ARM: inv_arm_r <= cfg_data;
          CFG_GAIN:    gain_r <= cfg_data;
          CFG_MAX:     max_ms_r <= cfg_data[9:0];
          CFG_MIN:     min_ms_r <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (state_r == ST_PAIR || state_r == ST_THR) phase_r <= !phase_r;
      if (state_r == ST_THR && phase_r) carry_r[idx_r] <= cnew;
    end
    if (state_r == ST_IDLE && in_valid) begin
      frc_r[0] <= in_force_x;
      frc_r[1] <= in_force_y;
      frc_r[2] <= in_force_z;
      trq_r[0] <= in_torque_x;
      trq_r[1] <= in_torque_y;
      trq_r[2] <= in_torque_z;
      large_r <= '0;
      scale_r <= 1'b0;
    end
    if (state_r == ST_PAIR) begin
      if (!phase_r) begin
        mag_r <= mag;
        neg_r[idx_r[2:0]] <= dd[33];
      end else begin
        dem_r[idx_r[2:0]] <= pdem;
        if (pdem > large_r) large_r <= pdem;
        if (idx_r == 4'(PAIR_COUNT - 1))
          scale_r <= (large_r > max_fix || pdem > max_fix);
      end
    end
    if (state_r == ST_DIV && drsp.done) scl_r <= drsp.quotient[31:0];
    if (state_r == ST_THR) begin
      if (!phase_r) scl_r <= rawd;
      else begin
        on_r <= (pulse != 0) ? on_c : 10'd0;
        off_r <= (pulse != 0) ? on_c + pulse : 10'd0;
      end
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_out_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> idx_r < 4'(THRUSTER_COUNT))
    else $error("thruster index out of range");
  a_off_after_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_close_time >= out_on_time)
    else $error("window closes before it opens");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !out_valid)
    else $error("config open while results pending");
endmodule

FILE: bench/tpm_checker.sv
`timescale 1ns / 1ps
module tpm_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_force_x,
  input  logic signed [15:0] in_force_y,
  input  logic signed [15:0] in_force_z,
  input  logic signed [15:0] in_torque_x,
  input  logic signed [15:0] in_torque_y,
  input  logic signed [15:0] in_torque_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [3:0]         out_thruster_index,
  input  logic [9:0]         out_on_time,
  input  logic [9:0]         out_close_time,
  input  logic               out_last_thruster,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  import tpm_pkg::*;

  typedef struct packed {
    logic [3:0] idx;
    logic [9:0] on_t;
    logic [9:0] off_t;
    logic       last;
  } window_t;

  window_t window_q[$];
  logic [15:0] inv_arm, gain;
  logic [9:0] max_ms, min_ms;
  logic [19:0] carry[12];

  assign pending = window_q.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic mix_command(input logic signed [15:0] f[3], input logic signed [15:0] t[3]);
    longint frc[3], trq[3], dem[12], d, t_sel, c, pulse, on_t;
    longint unsigned mag, p, largest, max_fx, min_fx;
    window_t w;
    largest = 0;
    max_fx = longint'(max_ms) << 8;
    min_fx = longint'(min_ms) << 8;
    for (int i = 0; i < 3; i++) begin
      frc[i] = longint'(f[i]) * 256;
      trq[i] = longint'(t[i]) * longint'(inv_arm);
    end
    for (int i = 0; i < 12; i++) dem[i] = 0;
    for (int i = 0; i < 6; i++) begin
      t_sel = trq[((i >> 1) + 1) % 3];
      d = (i & 1) ? frc[i >> 1] - t_sel : frc[i >> 1] + t_sel;
      mag = d >= 0 ? d : -d;
      p = (longint'(gain) * mag) >> 21;
      dem[d >= 0 ? i : i + 6] = p;
      if (p > largest) largest = p;
    end
    if (largest > max_fx)
      for (int i = 0; i < 12; i++) dem[i] = longint'(dem[i] * max_fx / largest);
    for (int i = 0; i < 12; i++) begin
      c = longint'(carry[i]) + dem[i];
      pulse = 0;
      if (c > 64'hFFFFF) c = 64'hFFFFF;
      if (c >= min_fx) begin
        pulse = c >> 8;
        if (pulse > max_ms) pulse = max_ms;
        c -= pulse << 8;
      end
      carry[i] = c[19:0];
      on_t = pulse > 0 ? (longint'(max_ms) - pulse) / 2 : 0;
      w.idx = 4'(i);
      w.on_t = 10'(on_t);
      w.off_t = pulse > 0 ? 10'(on_t + pulse) : 10'd0;
      w.last = (i == 11);
      window_q.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    window_t w;
    if (!rst_n) begin
      inv_arm <= 16'd2560;
      gain <= 16'd25600;
      max_ms <= 10'd200;
      min_ms <= 10'd10;
      for (int i = 0; i < 12; i++) carry[i] = '0;
      window_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_INV_ARM: inv_arm <= cfg_data;
          CFG_GAIN:    gain <= cfg_data;
          CFG_MAX:     max_ms <= cfg_data[9:0];
          CFG_MIN:     min_ms <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        mix_command('{in_force_x, in_force_y, in_force_z},
                    '{in_torque_x, in_torque_y, in_torque_z});
      if (out_valid && !out_stall) begin
        if (window_q.size() == 0)
          report("unexpected beat", 32'(out_thruster_index), 32'd0);
        else begin
          w = window_q.pop_front();
          if (out_thruster_index !== w.idx)
            report("thruster_index", 32'(out_thruster_index), 32'(w.idx));
          if (out_on_time !== w.on_t) report("on_time", 32'(out_on_time), 32'(w.on_t));
          if (out_close_time !== w.off_t)
            report("close_time", 32'(out_close_time), 32'(w.off_t));
          if (out_last_thruster !== w.last)
            report("last_thruster", 32'(out_last_thruster), 32'(w.last));
        end
      end
    end
  end
endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import tpm_pkg::*;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic signed [15:0] fx = 0, fy = 0, fz = 0, tx = 0, ty = 0, tz = 0;
  logic [3:0] o_idx;
  logic [9:0] o_on, o_off;
  logic o_last;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = CFG_INV_ARM;
  logic [15:0] cfg_data = 0;
  int fail_count, pending;
  int send_idle = 0, recv_idle = 0; // idle chance in percent
  int quiet = 0;                    // cycles since anything moved

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  thruster_pulse_mixer uut (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_force_x(fx), .in_force_y(fy), .in_force_z(fz),
    .in_torque_x(tx), .in_torque_y(ty), .in_torque_z(tz),
    .out_valid, .out_stall, .out_thruster_index(o_idx), .out_on_time(o_on),
    .out_close_time(o_off), .out_last_thruster(o_last),
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data);

  tpm_checker chk (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_force_x(fx), .in_force_y(fy), .in_force_z(fz),
    .in_torque_x(tx), .in_torque_y(ty), .in_torque_z(tz),
    .out_valid, .out_stall, .out_thruster_index(o_idx), .out_on_time(o_on),
    .out_close_time(o_off), .out_last_thruster(o_last),
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending);

  // receiver stalls at random, drawn fresh each cycle
  always @(posedge clk)
    out_stall <= rst_n && ($urandom_range(99) < recv_idle);

  // watchdog on cycles with no accepted beat of any kind
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("thruster_pulse_mixer: mismatch");
      $finish;
    end
  end

  // pick an edge-heavy 16-bit value now and then
  function automatic logic [15:0] pick16();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_command(input logic [15:0] a, b, c, d, e, f);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    fx <= a; fy <= b; fz <= c; tx <= d; ty <= e; tz <= f;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_random();
    send_command(pick16(), pick16(), pick16(), pick16(), pick16(), pick16());
  endtask

  // drain every expected window, then give the block time to settle
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] arm, g, mx, mn);
    drain();
    write_reg(CFG_INV_ARM, arm);
    write_reg(CFG_GAIN, g);
    write_reg(CFG_MAX, mx);
    write_reg(CFG_MIN, mn);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: zero, extremes on every axis, sign of each pair, carry build-up
    send_command(0, 0, 0, 0, 0, 0);
    send_command(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_command(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_command(16'h7fff, 0, 0, 0, 16'h8000, 0);
    send_command(0, 16'h8000, 0, 0, 0, 16'h7fff);
    send_command(0, 0, 16'h1000, 16'hf000, 0, 0);
    for (int i = 0; i < 6; i++) send_command(16'h0010, 0, 0, 0, 0, 0); // small carry
    // all-ones registers: carry saturation, widest window
    set_regs(16'hffff, 16'hffff, 16'd1023, 16'd1023);
    for (int i = 0; i < 5; i++) send_command(16'h7fff, 16'h8000, 16'h7fff, 0, 0, 0);
    // zero-ish registers: firing on tiny carry, minimal window
    set_regs(16'h0000, 16'h0000, 16'd1, 16'd0);
    send_command(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    set_regs(16'd256, 16'd256, 16'd0, 16'd1);
    send_command(16'h7fff, 0, 0, 0, 0, 0);
    set_regs(16'd2560, 16'd25600, 16'd200, 16'd10);

    // random phases with different idling mixes
    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph % 3 == 0) ? 35 : (ph % 3 == 1) ? 84 : 0;
      recv_idle = (ph % 3 == 0) ? 84 : (ph % 3 == 1) ? 35 : 0;
      if (ph > 0)
        set_regs(16'($urandom), 16'($urandom), 16'($urandom_range(1023, 1)),
                 16'($urandom_range(1023, 1)));
      for (int i = 0; i < 50; i++) begin
        send_random();
        if (i == 25) drain();
      end
    end
    send_idle = 0;
    recv_idle = 0;

    drain();
    if (fail_count == 0)
      $display("thruster_pulse_mixer: match");
    else
      $display("thruster_pulse_mixer: mismatch");
    $finish;
  end
endmodule

FILE: files.f
sv/tpm_pkg.sv
sv/tpm_div.sv
sv/thruster_pulse_mixer.sv
bench/tpm_checker.sv
bench/tb.sv
